@@ src/sm83_pkg.sv @@
// Shared types and helpers for the SM83-style ALU with flags.
// No dependencies; imported by every module of the block.
package sm83_pkg;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_ADC      = 4'd1,
        OP_SUB      = 4'd2,
        OP_SBC      = 4'd3,
        OP_AND      = 4'd4,
        OP_XOR      = 4'd5,
        OP_OR       = 4'd6,
        OP_CP       = 4'd7,
        OP_INC8     = 4'd8,
        OP_DEC8     = 4'd9,
        OP_DAA      = 4'd10,
        OP_CPL      = 4'd11,
        OP_ADD16    = 4'd12,
        OP_INC16    = 4'd13,
        OP_DEC16    = 4'd14,
        OP_ADDSPOFF = 4'd15
    } t_op;

    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    typedef struct packed {
        t_op         op;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [15:0] wide_left;
        logic [15:0] wide_right;
        t_flags      flags;
    } t_item;

    typedef struct packed {
        logic [7:0]  byte_res;
        logic [15:0] word_res;
        t_flags      flags;
    } t_result;

    function automatic logic is_wide_op(input t_op op);
        is_wide_op = (op == OP_ADD16) || (op == OP_INC16) || (op == OP_DEC16)
            || (op == OP_ADDSPOFF);
    endfunction

endpackage

@@ src/sm83_alu8.sv @@
// Eight-bit datapath: arithmetic, logic, INC/DEC, DAA and CPL with flags.
// Depends on sm83_pkg.
module sm83_alu8 (
    input  sm83_pkg::t_item   i_item,
    output sm83_pkg::t_result o_result
);
    import sm83_pkg::*;

    logic       cin;
    logic [8:0] add_full;
    logic [4:0] add_half;
    logic [8:0] sub_full;
    logic [4:0] sub_half;
    logic [7:0] logic_res;
    logic       daa_hi;
    logic       daa_lo;
    logic [7:0] daa_corr;
    logic [7:0] daa_res;
    logic [7:0] a;
    logic [7:0] b;

    assign a = i_item.acc;
    assign b = i_item.operand;
    assign cin = ((i_item.op == OP_ADC) || (i_item.op == OP_SBC)) ? i_item.flags.c : 1'b0;

    assign add_full = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign sub_full = {1'b0, a} - {1'b0, b} - {8'd0, cin};
    assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

    assign daa_hi = i_item.flags.c || (a > DAA_HI_LIMIT);
    assign daa_lo = i_item.flags.h || (a[3:0] > DAA_LO_LIMIT);
    always_comb begin
        daa_corr = 8'd0;
        if (i_item.flags.n) begin
            if (i_item.flags.c) begin
                daa_corr = daa_corr | DAA_HI_ADJ;
            end
            if (i_item.flags.h) begin
                daa_corr = daa_corr | DAA_LO_ADJ;
            end
        end else begin
            if (daa_hi) begin
                daa_corr = daa_corr | DAA_HI_ADJ;
            end
            if (daa_lo) begin
                daa_corr = daa_corr | DAA_LO_ADJ;
            end
        end
    end
    assign daa_res = i_item.flags.n ? (a - daa_corr) : (a + daa_corr);

    always_comb begin
        case (i_item.op)
            OP_AND:  logic_res = a & b;
            OP_XOR:  logic_res = a ^ b;
            default: logic_res = a | b;
        endcase
    end

    always_comb begin
        o_result.byte_res = a;
        o_result.word_res = 16'd0;
        o_result.flags    = i_item.flags;
        unique case (i_item.op) inside
            OP_ADD, OP_ADC: begin
                o_result.byte_res = add_full[7:0];
                o_result.flags.z  = (add_full[7:0] == 8'd0);
                o_result.flags.n  = 1'b0;
                o_result.flags.h  = add_half[4];
                o_result.flags.c  = add_full[8];
            end
            OP_SUB, OP_SBC, OP_CP: begin
                if (i_item.op != OP_CP) begin
                    o_result.byte_res = sub_full[7:0];
                end
                o_result.flags.z  = (sub_full[7:0] == 8'd0);
                o_result.flags.n  = 1'b1;
                o_result.flags.h  = sub_half[4];
                o_result.flags.c  = sub_full[8];
            end
            OP_AND, OP_XOR, OP_OR: begin
                o_result.byte_res = logic_res;
                o_result.flags.z  = (logic_res == 8'd0);
                o_result.flags.n  = 1'b0;
                o_result.flags.h  = (i_item.op == OP_AND);
                o_result.flags.c  = 1'b0;
            end
            OP_INC8: begin
                o_result.byte_res = b + 8'd1;
                o_result.flags.z  = (b == 8'hFF);
                o_result.flags.n  = 1'b0;
                o_result.flags.h  = (b[3:0] == 4'hF);
            end
            OP_DEC8: begin
                o_result.byte_res = b - 8'd1;
                o_result.flags.z  = (b == 8'h01);
                o_result.flags.n  = 1'b1;
                o_result.flags.h  = (b[3:0] == 4'h0);
            end
            OP_DAA: begin
                o_result.byte_res = daa_res;
                o_result.flags.z  = (daa_res == 8'd0);
                o_result.flags.h  = 1'b0;
                if (!i_item.flags.n && daa_hi) begin
                    o_result.flags.c = 1'b1;
                end
            end
            OP_CPL: begin
                o_result.byte_res = ~a;
                o_result.flags.n  = 1'b1;
                o_result.flags.h  = 1'b1;
            end
            default: begin
                o_result.byte_res = a;
            end
        endcase
    end

endmodule

@@ src/sm83_alu16.sv @@
// Sixteen-bit datapath: HL add, INC/DEC of a pair and SP plus signed offset.
// Depends on sm83_pkg.
module sm83_alu16 (
    input  sm83_pkg::t_item   i_item,
    output sm83_pkg::t_result o_result
);
    import sm83_pkg::*;

    logic [16:0] add_full;
    logic [12:0] add_half;
    logic [15:0] off_ext;
    logic [8:0]  off_low;
    logic [4:0]  off_half;

    assign add_full = {1'b0, i_item.wide_left} + {1'b0, i_item.wide_right};
    assign add_half = {1'b0, i_item.wide_left[11:0]} + {1'b0, i_item.wide_right[11:0]};
    assign off_ext  = {{8{i_item.operand[7]}}, i_item.operand};
    assign off_low  = {1'b0, i_item.wide_left[7:0]} + {1'b0, i_item.operand};
    assign off_half = {1'b0, i_item.wide_left[3:0]} + {1'b0, i_item.operand[3:0]};

    always_comb begin
        o_result.byte_res = i_item.acc;
        o_result.word_res = 16'd0;
        o_result.flags    = i_item.flags;
        unique case (i_item.op) inside
            OP_ADD16: begin
                o_result.word_res = add_full[15:0];
                o_result.flags.n  = 1'b0;
                o_result.flags.h  = add_half[12];
                o_result.flags.c  = add_full[16];
            end
            OP_INC16: begin
                o_result.word_res = i_item.wide_left + 16'd1;
            end
            OP_DEC16: begin
                o_result.word_res = i_item.wide_left - 16'd1;
            end
            OP_ADDSPOFF: begin
                o_result.word_res = i_item.wide_left + off_ext;
                o_result.flags.z  = 1'b0;
                o_result.flags.n  = 1'b0;
                o_result.flags.h  = off_half[4];
                o_result.flags.c  = off_low[8];
            end
            default: begin
                o_result.word_res = 16'd0;
            end
        endcase
    end

endmodule

@@ src/sm83_alu_with_flags.sv @@
// Top level of the SM83-style ALU: input register, both datapaths, result register.
// Depends on sm83_pkg, sm83_alu8 and sm83_alu16.
//
//   channel | handshake            | beat contents
//   input   | i_valid / o_stall    | opcode, accumulator, operands, Z/N/H/C in
//   output  | o_valid / i_stall    | byte result, word result, Z/N/H/C out
//
// A beat is taken into the input register, computed in one pass and lands in the
// result register once that register can take it; o_valid is its valid bit.
// One beat is accepted every cycle while the output is not stalled.
// Synchronous active-low reset empties both registers.
// A stall on the output backs up through the input register to o_stall.
module sm83_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_acc_value,
    input  logic [7:0]  i_operand_value,
    input  logic [15:0] i_wide_left,
    input  logic [15:0] i_wide_right,
    input  logic        i_zero_in,
    input  logic        i_subtract_in,
    input  logic        i_half_in,
    input  logic        i_carry_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_result_byte,
    output logic [15:0] o_result_word,
    output logic        o_zero_out,
    output logic        o_subtract_out,
    output logic        o_half_out,
    output logic        o_carry_out
);
    import sm83_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    t_result res8;
    t_result res16;
    logic    out_ready;
    logic    in_ready;

    assign out_ready = !r_out_valid || !i_stall;
    assign in_ready  = !r_in_valid || out_ready;
    assign o_stall   = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in.op         <= t_op'(i_opcode);
            r_in.acc        <= i_acc_value;
            r_in.operand    <= i_operand_value;
            r_in.wide_left  <= i_wide_left;
            r_in.wide_right <= i_wide_right;
            r_in.flags      <= '{z: i_zero_in, n: i_subtract_in, h: i_half_in, c: i_carry_in};
        end
    end

    sm83_alu8 u_alu8 (
        .i_item   (r_in),
        .o_result (res8)
    );

    sm83_alu16 u_alu16 (
        .i_item   (r_in),
        .o_result (res16)
    );

    assign n_out = is_wide_op(r_in.op) ? res16 : res8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_byte  = r_out.byte_res;
    assign o_result_word  = r_out.word_res;
    assign o_zero_out     = r_out.flags.z;
    assign o_subtract_out = r_out.flags.n;
    assign o_half_out     = r_out.flags.h;
    assign o_carry_out    = r_out.flags.c;

    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result register not empty after reset");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled while a stage is free");

    a_beat_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_ready) |=> o_valid)
        else $error("beat lost between input and result register");

    a_byte_ops_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !is_wide_op(r_in.op)) |-> (n_out.word_res == 16'd0))
        else $error("eight-bit operation produced a word result");

endmodule

@@ tb/sv/tb_sm83_alu_with_flags.sv @@
// Self-checking testbench for sm83_alu_with_flags: directed corner cases, then random opcodes,
// with random input gaps and output stalls, every result checked against a built-in predictor.
// Depends on sm83_pkg and the sm83_alu_with_flags RTL; needs no files or arguments.
module tb_sm83_alu_with_flags;
    import sm83_pkg::*;

    class alu_result_tracker;
        t_result     expected_q[$];
        int unsigned failures;
        int unsigned checked;

        function t_result predict(t_item it);
            t_result    r;
            t_flags     f;
            logic [7:0] a;
            logic [7:0] b;
            logic       cin;
            logic [8:0] s9;
            logic [4:0] s5;
            logic [16:0] s17;
            logic [12:0] s13;
            a = it.acc;
            b = it.operand;
            f = it.flags;
            r.byte_res = a;
            r.word_res = 16'h0000;
            case (it.op)
                OP_ADD, OP_ADC: begin
                    cin = (it.op == OP_ADC) ? f.c : 1'b0;
                    s9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
                    s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
                    r.byte_res = s9[7:0];
                    f.z = (s9[7:0] == 8'h00);
                    f.n = 1'b0;
                    f.h = s5[4];
                    f.c = s9[8];
                end
                OP_SUB, OP_SBC, OP_CP: begin
                    cin = (it.op == OP_SBC) ? f.c : 1'b0;
                    s9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
                    s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
                    if (it.op != OP_CP) begin
                        r.byte_res = s9[7:0];
                    end
                    f.z = (s9[7:0] == 8'h00);
                    f.n = 1'b1;
                    f.h = s5[4];
                    f.c = s9[8];
                end
                OP_AND, OP_XOR, OP_OR: begin
                    if (it.op == OP_AND) begin
                        r.byte_res = a & b;
                    end else if (it.op == OP_XOR) begin
                        r.byte_res = a ^ b;
                    end else begin
                        r.byte_res = a | b;
                    end
                    f.z = (r.byte_res == 8'h00);
                    f.n = 1'b0;
                    f.h = (it.op == OP_AND);
                    f.c = 1'b0;
                end
                OP_INC8: begin
                    r.byte_res = b + 8'h01;
                    f.z = (r.byte_res == 8'h00);
                    f.n = 1'b0;
                    f.h = (b[3:0] == 4'hF);
                end
                OP_DEC8: begin
                    r.byte_res = b - 8'h01;
                    f.z = (r.byte_res == 8'h00);
                    f.n = 1'b1;
                    f.h = (b[3:0] == 4'h0);
                end
                OP_DAA: begin
                    if (!f.n) begin
                        if (f.c || a > DAA_HI_LIMIT) begin
                            r.byte_res = r.byte_res + DAA_HI_ADJ;
                            f.c = 1'b1;
                        end
                        if (f.h || a[3:0] > DAA_LO_LIMIT) begin
                            r.byte_res = r.byte_res + DAA_LO_ADJ;
                        end
                    end else begin
                        if (f.c) begin
                            r.byte_res = r.byte_res - DAA_HI_ADJ;
                        end
                        if (f.h) begin
                            r.byte_res = r.byte_res - DAA_LO_ADJ;
                        end
                    end
                    f.z = (r.byte_res == 8'h00);
                    f.h = 1'b0;
                end
                OP_CPL: begin
                    r.byte_res = ~a;
                    f.n = 1'b1;
                    f.h = 1'b1;
                end
                OP_ADD16: begin
                    s17 = {1'b0, it.wide_left} + {1'b0, it.wide_right};
                    s13 = {1'b0, it.wide_left[11:0]} + {1'b0, it.wide_right[11:0]};
                    r.word_res = s17[15:0];
                    f.n = 1'b0;
                    f.h = s13[12];
                    f.c = s17[16];
                end
                OP_INC16: begin
                    r.word_res = it.wide_left + 16'h0001;
                end
                OP_DEC16: begin
                    r.word_res = it.wide_left - 16'h0001;
                end
                default: begin
                    r.word_res = it.wide_left + {{8{b[7]}}, b};
                    s5 = {1'b0, it.wide_left[3:0]} + {1'b0, b[3:0]};
                    s9 = {1'b0, it.wide_left[7:0]} + {1'b0, b};
                    f.z = 1'b0;
                    f.n = 1'b0;
                    f.h = s5[4];
                    f.c = s9[8];
                end
            endcase
            r.flags = f;
            return r;
        endfunction

        function void note_operation(t_item it);
            expected_q.push_back(predict(it));
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %h, actual %h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("result beat arrived with no operation outstanding");
                failures++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("result_byte", {8'd0, want.byte_res}, {8'd0, got.byte_res});
            compare_field("result_word", want.word_res, got.word_res);
            compare_field("zero_out", {15'd0, want.flags.z}, {15'd0, got.flags.z});
            compare_field("subtract_out", {15'd0, want.flags.n}, {15'd0, got.flags.n});
            compare_field("half_out", {15'd0, want.flags.h}, {15'd0, got.flags.h});
            compare_field("carry_out", {15'd0, want.flags.c}, {15'd0, got.flags.c});
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_opcode;
    logic [7:0]  i_acc_value;
    logic [7:0]  i_operand_value;
    logic [15:0] i_wide_left;
    logic [15:0] i_wide_right;
    logic        i_zero_in;
    logic        i_subtract_in;
    logic        i_half_in;
    logic        i_carry_in;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_result_byte;
    logic [15:0] o_result_word;
    logic        o_zero_out;
    logic        o_subtract_out;
    logic        o_half_out;
    logic        o_carry_out;

    alu_result_tracker tracker;
    int unsigned       accepted_ops;
    bit                draining;
    bit                held_off;

    sm83_alu_with_flags i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_acc_value     (i_acc_value),
        .i_operand_value (i_operand_value),
        .i_wide_left     (i_wide_left),
        .i_wide_right    (i_wide_right),
        .i_zero_in       (i_zero_in),
        .i_subtract_in   (i_subtract_in),
        .i_half_in       (i_half_in),
        .i_carry_in      (i_carry_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_byte   (o_result_byte),
        .o_result_word   (o_result_word),
        .o_zero_out      (o_zero_out),
        .o_subtract_out  (o_subtract_out),
        .o_half_out      (o_half_out),
        .o_carry_out     (o_carry_out)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    function automatic t_item make_op(t_op op, logic [7:0] acc, logic [7:0] operand,
                                      logic [15:0] wl, logic [15:0] wr, logic [3:0] flags);
        t_item it;
        it.op = op;
        it.acc = acc;
        it.operand = operand;
        it.wide_left = wl;
        it.wide_right = wr;
        it.flags = t_flags'(flags);
        return it;
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
            3: return {4'($urandom_range(0, 15)), $urandom_range(0, 1) ? 4'hF : 4'h0};
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return $urandom_range(0, 1) ? 16'h0FFF : 16'h00FF;
            3: return {8'($urandom_range(0, 255)), $urandom_range(0, 1) ? 8'hFF : 8'h0F};
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_op(t_item it, int unsigned gap);
        if (gap != 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_opcode        <= it.op;
        i_acc_value     <= it.acc;
        i_operand_value <= it.operand;
        i_wide_left     <= it.wide_left;
        i_wide_right    <= it.wide_right;
        i_zero_in       <= it.flags.z;
        i_subtract_in   <= it.flags.n;
        i_half_in       <= it.flags.h;
        i_carry_in      <= it.flags.c;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        tracker.note_operation(it);
        accepted_ops++;
    endtask

    // Output side: random stall pattern, one long hold-off to back the block up, and
    // stall released for good once the drain begins.
    initial begin
        int unsigned run;
        int unsigned hold;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (draining) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (!held_off && accepted_ops >= 400) begin
                held_off = 1'b1;
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (79) @(negedge i_clk);
            end else begin
                run = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 8);
                hold = pick_idle();
                @(negedge i_clk);
                i_stall <= 1'b0;
                repeat (run - 1) @(negedge i_clk);
                if (hold != 0) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                    repeat (hold - 1) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        t_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.byte_res = o_result_byte;
                got.word_res = o_result_word;
                got.flags = '{z: o_zero_out, n: o_subtract_out, h: o_half_out,
                              c: o_carry_out};
                tracker.check_result(got);
            end
        end
    end

    initial begin
        #3_200_000;
        $display("sm83_alu_with_flags regression: fail");
        $finish;
    end

    initial begin
        t_item       it;
        bit          quiet;
        int unsigned gap;
        tracker = new();
        accepted_ops = 0;
        draining = 1'b0;
        held_off = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = 4'h0;
        i_acc_value = 8'h00;
        i_operand_value = 8'h00;
        i_wide_left = 16'h0000;
        i_wide_right = 16'h0000;
        i_zero_in = 1'b0;
        i_subtract_in = 1'b0;
        i_half_in = 1'b0;
        i_carry_in = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner cases: carries and borrows out of both nibbles, zero results, compare,
        // decimal adjust after add and subtract, wide wraps and negative offsets.
        send_op(make_op(OP_ADD, 8'hFF, 8'h01, 16'h0000, 16'h0000, 4'h0), 0);
        send_op(make_op(OP_ADD, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 4'hF), 0);
        send_op(make_op(OP_ADC, 8'hFF, 8'h00, 16'h0000, 16'h0000, 4'h1), 0);
        send_op(make_op(OP_ADC, 8'h0E, 8'h01, 16'h0000, 16'h0000, 4'h1), 0);
        send_op(make_op(OP_SUB, 8'h00, 8'h01, 16'h0000, 16'h0000, 4'h0), 0);
        send_op(make_op(OP_SUB, 8'h80, 8'h80, 16'h0000, 16'h0000, 4'hF), 0);
        send_op(make_op(OP_SBC, 8'h10, 8'h0F, 16'h0000, 16'h0000, 4'h1), 0);
        send_op(make_op(OP_SBC, 8'h00, 8'hFF, 16'h0000, 16'h0000, 4'h1), 0);
        send_op(make_op(OP_AND, 8'hF0, 8'h0F, 16'h0000, 16'h0000, 4'hF), 0);
        send_op(make_op(OP_XOR, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 4'hF), 0);
        send_op(make_op(OP_OR, 8'h00, 8'h00, 16'h0000, 16'h0000, 4'h0), 0);
        send_op(make_op(OP_CP, 8'h42, 8'h42, 16'h0000, 16'h0000, 4'h0), 0);
        send_op(make_op(OP_CP, 8'h00, 8'hFF, 16'h0000, 16'h0000, 4'h0), 0);
        send_op(make_op(OP_INC8, 8'h00, 8'hFF, 16'h0000, 16'h0000, 4'h1), 0);
        send_op(make_op(OP_DEC8, 8'hFF, 8'h00, 16'h0000, 16'h0000, 4'h0), 0);
        send_op(make_op(OP_DEC8, 8'h00, 8'h01, 16'h0000, 16'h0000, 4'hF), 0);
        send_op(make_op(OP_DAA, 8'h9A, 8'h00, 16'h0000, 16'h0000, 4'h0), 0);
        send_op(make_op(OP_DAA, 8'h00, 8'h00, 16'h0000, 16'h0000, 4'h7), 0);
        send_op(make_op(OP_DAA, 8'h66, 8'h00, 16'h0000, 16'h0000, 4'h3), 0);
        send_op(make_op(OP_CPL, 8'h5A, 8'h00, 16'h0000, 16'h0000, 4'h9), 0);
        send_op(make_op(OP_ADD16, 8'h11, 8'h00, 16'hFFFF, 16'h0001, 4'hF), 0);
        send_op(make_op(OP_ADD16, 8'h22, 8'h00, 16'h0FFF, 16'h0001, 4'h0), 0);
        send_op(make_op(OP_INC16, 8'h33, 8'h00, 16'hFFFF, 16'h0000, 4'hA), 0);
        send_op(make_op(OP_DEC16, 8'h44, 8'h00, 16'h0000, 16'h0000, 4'h5), 0);
        send_op(make_op(OP_ADDSPOFF, 8'h55, 8'h80, 16'h00FF, 16'h0000, 4'hF), 0);
        send_op(make_op(OP_ADDSPOFF, 8'h66, 8'hFF, 16'h0000, 16'h0000, 4'hF), 2);

        quiet = 1'b0;
        for (int i = 0; i < 1550; i++) begin
            if (i % 128 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            it = make_op(t_op'($urandom_range(0, 15)), pick_byte(), pick_byte(), pick_word(),
                         pick_word(), 4'($urandom_range(0, 15)));
            gap = quiet ? 0 : pick_idle();
            send_op(it, gap);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        draining = 1'b1;

        while (tracker.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered all sixteen opcodes: %0d operations sent, %0d results checked.",
                 accepted_ops, tracker.checked);
        $display("Both channels idled at random, with one long output hold-off; %0d mismatches.",
                 tracker.failures);
        if (tracker.failures == 0) begin
            $display("sm83_alu_with_flags regression: pass");
        end else begin
            $display("sm83_alu_with_flags regression: fail");
        end
        $finish;
    end

endmodule
